@@ rtl/pfs_pkg.sv @@
`default_nettype none

package pfs_pkg;

    // Field widths fixed by the stream format
    localparam int PIXEL_W      = 16;
    localparam int FRAC_BITS    = 8;
    localparam int QUOT_W       = PIXEL_W + FRAC_BITS;
    localparam int CNT_FIELD_W  = 25;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_FIELDS_W = 2 * CNT_FIELD_W + 2 * PIXEL_W + 2 * QUOT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Default accumulator depth: counts saturate at 2**COUNT_BITS
    localparam int COUNT_BITS_DEF = 24;

    localparam logic [PIXEL_W-1:0] OVERLOAD_RESET = 16'd65530;
    localparam logic [PIXEL_W-1:0] PIXEL_MAX      = 16'd65535;

    // Frame-end arithmetic sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_ROOT,
        ST_SD_DIV,
        ST_MEAN_DIV,
        ST_DONE
    } post_state_t;

    // Requests from the accumulator side to the frame-end unit
    typedef struct packed {
        logic start;
        logic done_ready;
    } post_ctrl_t;

    // Status from the frame-end unit
    typedef struct packed {
        logic idle;
        logic done_valid;
    } post_stat_t;

endpackage

`default_nettype wire

@@ rtl/pixel_frame_statistics.sv @@
`default_nettype none

// Frame statistics over a stream of 16-bit pixels, one pixel per request on the
// slave side with tlast on the final pixel of the frame. Pixels pass through a
// two-stage pipeline (square, then accumulate) and are taken one per cycle
// while the frame-end unit is idle and no last pixel waits in the square stage.
// The last pixel of a frame launches the frame-end unit, which runs the mean
// and standard deviation on one shared adder/subtractor: a shift-add multiply
// of COUNT_BITS+1 steps, a second of COUNT_BITS+16 steps, a square root of
// COUNT_BITS+25 steps and two 24-step divisions. s_tready stays low from
// accepting a last pixel until the result is loaded into a free output
// register. The result sits in an output register, so pixels of the next frame
// are taken while it waits. overload_level is written through cfg_we/cfg_wdata,
// which the user must do only between frames; the block does not enforce it.

module pixel_frame_statistics
    import pfs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [PIXEL_W-1:0]      cfg_wdata,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_tdata,    // [15:0] pixel
    input  wire logic                    s_tlast,    // last_pixel
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]       m_tdata     // [24:0] pixel_count,
                                                     // [40:25] min_value,
                                                     // [56:41] max_value,
                                                     // [80:57] mean_q8,
                                                     // [104:81] stddev_q8,
                                                     // [129:105] overload_count,
                                                     // [135:130] zero
);

    localparam int CNT_W = COUNT_BITS + 1;
    localparam int SUM_W = COUNT_BITS + PIXEL_W;
    localparam int SQ_W  = COUNT_BITS + 2 * PIXEL_W;

    logic [PIXEL_W-1:0]      level_reg;

    logic                    stg_valid_reg;
    logic                    stg_last_reg;
    logic [PIXEL_W-1:0]      stg_px_reg;
    logic [2*PIXEL_W-1:0]    stg_pxsq_reg;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [PIXEL_W-1:0]      min_reg, min_next;
    logic [PIXEL_W-1:0]      max_reg, max_next;
    logic [CNT_W-1:0]        ovl_reg, ovl_next;

    logic [CNT_FIELD_W-1:0]  cnt_hold_reg;
    logic [PIXEL_W-1:0]      min_hold_reg;
    logic [PIXEL_W-1:0]      max_hold_reg;
    logic [CNT_FIELD_W-1:0]  ovl_hold_reg;

    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;

    post_ctrl_t              post_ctrl;
    post_stat_t              post_stat;
    logic [QUOT_W-1:0]       post_mean;
    logic [QUOT_W-1:0]       post_sd;
    logic                    in_fire;
    logic                    out_free;

    assign s_tready = post_stat.idle && !(stg_valid_reg && stg_last_reg);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign post_ctrl.start      = stg_valid_reg && stg_last_reg;
    assign post_ctrl.done_ready = out_free;

    // Hold the overload level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= OVERLOAD_RESET;
        end
        else if (cfg_we)
        begin
            level_reg <= cfg_wdata;
        end
    end

    // Capture the request and square the pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stg_px_reg   <= s_tdata[PIXEL_W-1:0];
            stg_pxsq_reg <= s_tdata[PIXEL_W-1:0] * s_tdata[PIXEL_W-1:0];
            stg_last_reg <= s_tlast;
        end
    end

    // Accumulate the staged pixel; count, sum and squares stop at saturation
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        ovl_next   = ovl_reg;
        if (stg_valid_reg)
        begin
            if (!count_reg[CNT_W-1])
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(stg_px_reg);
                sq_next    = sq_reg + SQ_W'(stg_pxsq_reg);
            end
            if (stg_px_reg < min_reg)
            begin
                min_next = stg_px_reg;
            end
            if (stg_px_reg > max_reg)
            begin
                max_next = stg_px_reg;
            end
            if (stg_px_reg >= level_reg && !ovl_reg[CNT_W-1])
            begin
                ovl_next = ovl_reg + 1'b1;
            end
        end
    end

    // Advance the accumulators; clear them when the frame is handed off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            min_reg   <= PIXEL_MAX;
            max_reg   <= '0;
            ovl_reg   <= '0;
        end
        else if (post_ctrl.start)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            min_reg   <= PIXEL_MAX;
            max_reg   <= '0;
            ovl_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sq_reg    <= sq_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            ovl_reg   <= ovl_next;
        end
    end

    // Hold the plain fields of the finished frame
    always_ff @(posedge clk)
    begin
        if (post_ctrl.start)
        begin
            cnt_hold_reg <= CNT_FIELD_W'(count_next);
            min_hold_reg <= min_next;
            max_hold_reg <= max_next;
            ovl_hold_reg <= CNT_FIELD_W'(ovl_next);
        end
    end

    pfs_post #(
        .COUNT_BITS (COUNT_BITS)
    ) u_post (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (post_ctrl),
        .n_in   (count_next),
        .sum_in (sum_next),
        .sq_in  (sq_next),
        .stat   (post_stat),
        .mean   (post_mean),
        .stddev (post_sd)
    );

    // Load the output register when the result is ready and the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (post_stat.done_valid && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (post_stat.done_valid && out_free)
        begin
            m_tdata_reg <= OUT_TDATA_W'({ovl_hold_reg, post_sd, post_mean,
                                         max_hold_reg, min_hold_reg, cnt_hold_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Accumulators start from reset values after a frame is handed off
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        post_ctrl.start |=> (count_reg == '0 && min_reg == PIXEL_MAX && ovl_reg == '0))
        else $error("accumulators not cleared after last pixel");

    // The pixel count never passes its saturation value
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[CNT_W-1] |-> (count_reg[CNT_W-2:0] == '0))
        else $error("pixel count beyond saturation");

    // A stalled result holds steady until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

@@ rtl/pfs_post.sv @@
`default_nettype none

module pfs_post
    import pfs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire post_ctrl_t                       ctrl,
    input  wire logic [COUNT_BITS:0]              n_in,
    input  wire logic [COUNT_BITS+PIXEL_W-1:0]    sum_in,
    input  wire logic [COUNT_BITS+2*PIXEL_W-1:0]  sq_in,
    output post_stat_t                            stat,
    output logic [QUOT_W-1:0]                     mean,
    output logic [QUOT_W-1:0]                     stddev
);

    localparam int CNT_W  = COUNT_BITS + 1;
    localparam int SUM_W  = COUNT_BITS + PIXEL_W;
    localparam int SQ_W   = COUNT_BITS + 2 * PIXEL_W;
    // n*sum2 and sum*sum both fit here; the running difference never goes negative
    localparam int ACC_W  = CNT_W + SQ_W;
    // Radicand is the variance term scaled by 2**(2*FRAC_BITS)
    localparam int RES_W  = (ACC_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * RES_W;
    localparam int REM_W  = RES_W + 2;
    localparam int STEP_W = $clog2(RES_W);

    post_state_t               state_reg;
    post_state_t               state_next;
    logic [STEP_W-1:0]         step_reg;
    logic                      step_last;

    logic [CNT_W-1:0]          n_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          mcand_reg;
    logic [SUM_W-1:0]          mplier_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [RES_W-1:0]          root_reg;
    logic [QUOT_W-1:0]         qd_reg;
    logic [QUOT_W-1:0]         sd_reg;

    logic [ACC_W-1:0]          alu_a;
    logic [ACC_W-1:0]          alu_b;
    logic                      alu_sub;
    logic [ACC_W:0]            alu_res;
    logic                      alu_borrow;

    logic [ACC_W-1:0]          acc_step;
    logic [QUOT_W-1:0]         qd_shift;
    logic [REM_W-1:0]          div_rem_next;
    logic [RES_W-1:0]          root_shift;
    logic [REM_W-1:0]          root_rem_next;

    assign step_last = (step_reg == '0);

    // Shared adder/subtractor; the top bit is the borrow when subtracting
    assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                                : ({1'b0, alu_a} + {1'b0, alu_b});
    assign alu_borrow = alu_res[ACC_W];

    // Step results of each phase
    assign acc_step      = mplier_reg[0] ? alu_res[ACC_W-1:0] : acc_reg;
    assign qd_shift      = {qd_reg[QUOT_W-2:0], !alu_borrow};
    assign div_rem_next  = alu_borrow ? REM_W'({rem_reg[CNT_W-1:0], qd_reg[QUOT_W-1]})
                                      : REM_W'(alu_res[CNT_W-1:0]);
    assign root_shift    = {root_reg[RES_W-2:0], !alu_borrow};
    assign root_rem_next = alu_borrow ? REM_W'({rem_reg, rad_reg[RAD_W-1 -: 2]})
                                      : alu_res[REM_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                if (step_last)
                begin
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B:
            begin
                if (step_last)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (step_last)
                begin
                    state_next = ST_SD_DIV;
                end
            end
            ST_SD_DIV:
            begin
                if (step_last)
                begin
                    state_next = ST_MEAN_DIV;
                end
            end
            ST_MEAN_DIV:
            begin
                if (step_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ctrl.done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Outputs and operand selection for the shared unit
    always_comb
    begin
        stat.idle       = (state_reg == ST_IDLE);
        stat.done_valid = (state_reg == ST_DONE);
        alu_a   = acc_reg;
        alu_b   = mcand_reg;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_IDLE, ST_DONE, ST_MUL_A:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
            ST_MUL_B:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b1;
            end
            ST_ROOT:
            begin
                alu_a   = ACC_W'({rem_reg, rad_reg[RAD_W-1 -: 2]});
                alu_b   = ACC_W'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            ST_SD_DIV, ST_MEAN_DIV:
            begin
                alu_a   = ACC_W'({rem_reg[CNT_W-1:0], qd_reg[QUOT_W-1]});
                alu_b   = ACC_W'(n_reg);
                alu_sub = 1'b1;
            end
        endcase
    end

    assign mean   = qd_reg;
    assign stddev = sd_reg;

    // Sequencer state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            priority if (state_reg == ST_IDLE && ctrl.start)
            begin
                step_reg <= STEP_W'(CNT_W - 1);
            end
            else if (state_reg == ST_MUL_A && step_last)
            begin
                step_reg <= STEP_W'(SUM_W - 1);
            end
            else if (state_reg == ST_MUL_B && step_last)
            begin
                step_reg <= STEP_W'(RES_W - 1);
            end
            else if ((state_reg == ST_ROOT || state_reg == ST_SD_DIV) && step_last)
            begin
                step_reg <= STEP_W'(QUOT_W - 1);
            end
            else if (!step_last)
            begin
                step_reg <= step_reg - 1'b1;
            end
            else
            begin
                step_reg <= step_reg;
            end
        end
    end

    // Datapath: multiply by shift-add, digit-by-digit root, restoring divide
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    n_reg      <= n_in;
                    sum_reg    <= sum_in;
                    acc_reg    <= '0;
                    mcand_reg  <= ACC_W'(sq_in);
                    mplier_reg <= SUM_W'(n_in);
                end
            end
            ST_MUL_A:
            begin
                acc_reg <= acc_step;
                if (step_last)
                begin
                    mcand_reg  <= ACC_W'(sum_reg);
                    mplier_reg <= sum_reg;
                end
                else
                begin
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            ST_MUL_B:
            begin
                acc_reg    <= acc_step;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                if (step_last)
                begin
                    rad_reg  <= RAD_W'({acc_step, {(2 * FRAC_BITS){1'b0}}});
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            ST_ROOT:
            begin
                rad_reg <= rad_reg << 2;
                if (step_last)
                begin
                    rem_reg <= REM_W'(root_shift >> QUOT_W);
                    qd_reg  <= root_shift[QUOT_W-1:0];
                end
                else
                begin
                    rem_reg  <= root_rem_next;
                    root_reg <= root_shift;
                end
            end
            ST_SD_DIV:
            begin
                if (step_last)
                begin
                    sd_reg  <= qd_shift;
                    rem_reg <= REM_W'(sum_reg >> PIXEL_W);
                    qd_reg  <= {sum_reg[PIXEL_W-1:0], {FRAC_BITS{1'b0}}};
                end
                else
                begin
                    rem_reg <= div_rem_next;
                    qd_reg  <= qd_shift;
                end
            end
            ST_MEAN_DIV:
            begin
                rem_reg <= div_rem_next;
                qd_reg  <= qd_shift;
            end
            ST_DONE:
            begin
                qd_reg <= qd_reg;
            end
        endcase
    end

    // A frame may only be launched into an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == ST_IDLE)
        else $error("frame launched while the frame-end unit is busy");

    // n*sum2 - partial sum^2 stays non-negative
    a_var_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_B && mplier_reg[0]) |-> !alu_borrow)
        else $error("variance term went negative");

    // Division remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SD_DIV || state_reg == ST_MEAN_DIV)
            |-> rem_reg < REM_W'(n_reg))
        else $error("division remainder not below pixel count");

endmodule

`default_nettype wire

@@ tb/sv/tb_pixel_frame_statistics.sv @@
`timescale 1ns / 1ps

module tb_pixel_frame_statistics;
    import pfs_pkg::*;

    // Settle long enough for the frame-end unit to finish, with margin
    localparam int SETTLE_CYCLES = 3 * COUNT_BITS_DEF + 92 + 40;
    localparam int PHASE_ITEMS   = 200;
    localparam int DIR_N         = 17;

    typedef struct packed {
        logic [24:0] cnt;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [23:0] mean;
        logic [23:0] sd;
        logic [24:0] ovl;
    } frame_stats_t;

    typedef struct packed {
        logic [15:0]  px;
        logic         last;
        logic         typed;
        frame_stats_t want;
    } pixel_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [PIXEL_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Frame accumulators of the predictor
    logic [24:0] acc_cnt;
    logic [39:0] acc_sum;
    logic [55:0] acc_sq;
    logic [15:0] acc_min;
    logic [15:0] acc_max;
    logic [24:0] acc_ovl;
    logic [15:0] level_model;

    frame_stats_t pending_stats[$];
    int err_count = 0;
    int sender_gap_pct = 0;
    int recv_stall_pct = 0;

    // Directed frames: extremes, overload boundary, bit patterns
    pixel_row_t dir_rows [DIR_N] = '{
        '{16'd0,     1'b1, 1'b1, '{25'd1, 16'd0, 16'd0, 24'd0, 24'd0, 25'd0}},
        '{16'd65535, 1'b1, 1'b1,
          '{25'd1, 16'd65535, 16'd65535, 24'd16776960, 24'd0, 25'd1}},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd65535, 1'b1, 1'b1,
          '{25'd2, 16'd0, 16'd65535, 24'd8388480, 24'd8388480, 25'd1}},
        '{16'd65529, 1'b0, 1'b0, '0},
        '{16'd65530, 1'b0, 1'b0, '0},
        '{16'd65531, 1'b1, 1'b0, '0},
        '{16'hAAAA,  1'b0, 1'b0, '0},
        '{16'h5555,  1'b0, 1'b0, '0},
        '{16'hFFFE,  1'b0, 1'b0, '0},
        '{16'h0001,  1'b1, 1'b0, '0},
        '{16'd100,   1'b0, 1'b0, '0},
        '{16'd200,   1'b0, 1'b0, '0},
        '{16'd300,   1'b0, 1'b0, '0},
        '{16'd401,   1'b1, 1'b0, '0},
        '{16'd65530, 1'b1, 1'b1,
          '{25'd1, 16'd65530, 16'd65530, 24'd16775680, 24'd0, 25'd1}},
        '{16'd65529, 1'b1, 1'b1,
          '{25'd1, 16'd65529, 16'd65529, 24'd16775424, 24'd0, 25'd0}}
    };

    pixel_frame_statistics #(
        .COUNT_BITS (COUNT_BITS_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock generation
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] rem;
        res = '0;
        rem = x;
        b = 64'h1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic clear_accumulators();
        acc_cnt = '0;
        acc_sum = '0;
        acc_sq  = '0;
        acc_min = PIXEL_MAX;
        acc_max = '0;
        acc_ovl = '0;
    endtask

    // Fold one accepted pixel into the predictor; close the frame on last
    task automatic absorb_pixel(input logic [15:0] px, input logic last,
                                output logic done, output frame_stats_t r);
        logic [127:0] var_n2;
        logic [127:0] quot;
        logic [63:0]  mean_w;
        done = 1'b0;
        r = '0;
        if (acc_cnt < 25'(1 << COUNT_BITS_DEF))
        begin
            acc_cnt = acc_cnt + 25'd1;
            acc_sum = acc_sum + 40'(px);
            acc_sq  = acc_sq + 56'(32'(px) * 32'(px));
        end
        if (px < acc_min)
            acc_min = px;
        if (px > acc_max)
            acc_max = px;
        if (px >= level_model && acc_ovl < 25'(1 << COUNT_BITS_DEF))
            acc_ovl = acc_ovl + 25'd1;
        if (last)
        begin
            var_n2 = 128'(acc_cnt) * 128'(acc_sq) - 128'(acc_sum) * 128'(acc_sum);
            quot   = (var_n2 << 16) / (128'(acc_cnt) * 128'(acc_cnt));
            mean_w = (64'(acc_sum) << 8) / 64'(acc_cnt);
            r.cnt  = acc_cnt;
            r.mn   = acc_min;
            r.mx   = acc_max;
            r.mean = mean_w[23:0];
            r.sd   = 24'(int_sqrt(quot[63:0]));
            r.ovl  = acc_ovl;
            done   = 1'b1;
            clear_accumulators();
        end
    endtask

    // Offer one pixel and hold it until the block takes it
    task automatic send_pixel(input logic [15:0] px, input logic last,
                              input logic typed, input frame_stats_t typed_want);
        logic         done;
        frame_stats_t r;
        while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        absorb_pixel(px, last, done, r);
        if (done)
            pending_stats.push_back(typed ? typed_want : r);
    endtask

    // Drop valid and hold off until every pending result has arrived
    task automatic wait_results();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_level(input logic [15:0] value);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        level_model = value;
    endtask

    // One random frame: mixed values, a constant level, or two values
    task automatic send_frame(input int len);
        int          style;
        int          k;
        int          t;
        logic [15:0] base_a;
        logic [15:0] base_b;
        logic [15:0] px;
        style  = $urandom_range(9);
        base_a = 16'($urandom);
        base_b = 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            if (style == 0)
                px = base_a;
            else if (style == 1)
                px = $urandom_range(1) ? base_a : base_b;
            else
            begin
                k = $urandom_range(9);
                if (k < 5)
                    px = 16'($urandom);
                else if (k == 5)
                    px = 16'($urandom_range(15));
                else if (k == 6)
                    px = 16'(65520 + $urandom_range(15));
                else if (k == 7)
                    px = level_model;
                else
                begin
                    t = int'(level_model) + int'($urandom_range(6)) - 3;
                    if (t < 0)
                        t = 0;
                    if (t > 65535)
                        t = 65535;
                    px = 16'(t);
                end
            end
            send_pixel(px, i == len - 1, 1'b0, '0);
        end
    endtask

    // Receiver: check each accepted result, then pick the next ready
    always @(posedge clk)
    begin : result_check
        frame_stats_t got;
        frame_stats_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.cnt  = m_tdata[24:0];
                got.mn   = m_tdata[40:25];
                got.mx   = m_tdata[56:41];
                got.mean = m_tdata[80:57];
                got.sd   = m_tdata[104:81];
                got.ovl  = m_tdata[129:105];
                if (pending_stats.size() == 0)
                begin
                    report_mismatch("result with no frame pending, pixel_count",
                                    64'(got.cnt), 64'd0);
                end
                else
                begin
                    want = pending_stats.pop_front();
                    if (got.cnt != want.cnt)
                        report_mismatch("pixel_count", 64'(got.cnt), 64'(want.cnt));
                    if (got.mn != want.mn)
                        report_mismatch("min_value", 64'(got.mn), 64'(want.mn));
                    if (got.mx != want.mx)
                        report_mismatch("max_value", 64'(got.mx), 64'(want.mx));
                    if (got.mean != want.mean)
                        report_mismatch("mean_q8", 64'(got.mean), 64'(want.mean));
                    if (got.sd != want.sd)
                        report_mismatch("stddev_q8", 64'(got.sd), 64'(want.sd));
                    if (got.ovl != want.ovl)
                        report_mismatch("overload_count", 64'(got.ovl), 64'(want.ovl));
                end
            end
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Main sequence
    initial
    begin : stimulus
        int          items;
        int          len;
        int          frames;
        logic [15:0] phase_level;
        level_model = OVERLOAD_RESET;
        clear_accumulators();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset overload level
        for (int i = 0; i < DIR_N; i++)
            send_pixel(dir_rows[i].px, dir_rows[i].last, dir_rows[i].typed,
                       dir_rows[i].want);

        // Random phases, each writing a new level and setting its idling pattern
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: phase_level = 16'd0;
                1: phase_level = PIXEL_MAX;
                4: phase_level = OVERLOAD_RESET;
                default: phase_level = 16'($urandom);
            endcase
            write_level(phase_level);
            case (ph)
                1: begin sender_gap_pct = 77; recv_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  recv_stall_pct = 77; end
                3: begin sender_gap_pct = 20; recv_stall_pct = 20; end
                default: begin sender_gap_pct = 0; recv_stall_pct = 0; end
            endcase
            items = 0;
            frames = 0;
            while (items < PHASE_ITEMS)
            begin
                len = $urandom_range(19);
                if (len < 14)
                    len = $urandom_range(8, 1);
                else if (len < 19)
                    len = $urandom_range(32, 9);
                else
                    len = $urandom_range(300, 100);
                send_frame(len);
                items += len;
                // After the first frame and at random, hold the sender until the block has delivered everything
                if (frames == 0 || $urandom_range(5) == 0)
                    wait_results();
                frames++;
            end
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_stats.size() != 0)
            report_mismatch("results missing at end", 64'd0,
                            64'(pending_stats.size()));
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pfs_pkg.sv
rtl/pfs_post.sv
rtl/pixel_frame_statistics.sv
tb/sv/tb_pixel_frame_statistics.sv
